>>> rtl/rrsq_pkg.sv
`timescale 1ns / 1ps

package rrsq_pkg;

  // Grid and value limits
  localparam int MAX_N      = 256;
  localparam int VALUE_BITS = 16;

  // Fixed field widths of the item ports
  localparam int ELEM_W  = 16;
  localparam int COORD_W = 9;
  localparam int SUM_W   = 32;

  // Derived storage widths
  localparam int ROW_W  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int ADDR_W = 2 * ROW_W;
  localparam int USE_W  = (VALUE_BITS < ELEM_W) ? VALUE_BITS : ELEM_W;
  localparam int PFX_W  = USE_W + ROW_W;
  localparam int DEPTH  = MAX_N * MAX_N;

  localparam logic [COORD_W-1:0] GRID_SIZE_RST = COORD_W'(256);

  // Request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic cfg_we;
    logic load;
    logic start;
    logic issue;
    logic post_ok;
    logic post_err;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic query_ok;
    logic last_row;
    logic out_busy;
  } stat_t;

endpackage

>>> rtl/rrsq_ctrl.sv
`timescale 1ns / 1ps

module rrsq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_req_type,
  output logic           in_stall,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  rrsq_pkg::stat_t stat,
  output rrsq_pkg::cmd_t  cmd
);
  import rrsq_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    accept    = 1'b0;
    case (state_r)
      S_IDLE: begin
        cfg_ready  = 1'b1;
        cmd.cfg_we = cfg_valid;
        // hold items while a register write lands; a query also needs a free output register
        in_stall   = cfg_valid || ((in_req_type == REQ_QUERY) && stat.out_busy);
        accept     = in_valid && !in_stall;
        if (accept && in_req_type == REQ_LOAD) begin
          cmd.load = 1'b1;
        end else if (accept) begin
          if (stat.query_ok) begin
            cmd.start = 1'b1;
            state_nxt = S_RUN;
          end else begin
            cmd.post_err = 1'b1;
          end
        end
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        if (stat.last_row) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last row's read data is summed this cycle
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.post_ok = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/rrsq_dp.sv
`timescale 1ns / 1ps

module rrsq_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rrsq_pkg::cmd_t                cmd,
  output rrsq_pkg::stat_t               stat,
  input  logic [rrsq_pkg::COORD_W-1:0]  cfg_grid_size,
  input  logic [rrsq_pkg::ELEM_W-1:0]   in_element_value,
  input  logic [rrsq_pkg::COORD_W-1:0]  in_top_row,
  input  logic [rrsq_pkg::COORD_W-1:0]  in_left_col,
  input  logic [rrsq_pkg::COORD_W-1:0]  in_bottom_row,
  input  logic [rrsq_pkg::COORD_W-1:0]  in_right_col,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rrsq_pkg::SUM_W-1:0]    out_rect_sum,
  output logic                          out_query_error
);
  import rrsq_pkg::*;

  logic [PFX_W-1:0] mem [0:DEPTH-1];

  logic [COORD_W-1:0] grid_size_r;
  logic [COORD_W-1:0] load_row_r, load_row_nxt;
  logic [COORD_W-1:0] load_col_r, load_col_nxt;
  logic [PFX_W-1:0]   running_r;
  logic               grid_loaded_r, grid_loaded_nxt;

  logic [COORD_W-1:0] n_eff;
  logic               restart;
  logic [COORD_W-1:0] eff_row, eff_col;
  logic [PFX_W-1:0]   pfx_nxt;
  logic [ADDR_W-1:0]  wr_addr;

  logic [ROW_W-1:0]   q_row_r, q_last_r, q_rcol_r, q_lcol_r;
  logic               q_lzero_r;
  logic [PFX_W-1:0]   rd_right_r, rd_left_r;
  logic               rd_vld_r;
  logic [PFX_W-1:0]   diff;
  logic [SUM_W-1:0]   acc_r;

  logic               out_valid_r;
  logic [SUM_W-1:0]   rect_sum_r;
  logic               query_error_r;

  // Size in use: zero acts as one, oversize clamps to the grid limit
  always_comb begin
    if (grid_size_r == '0) begin
      n_eff = COORD_W'(1);
    end else if (grid_size_r > MAX_N) begin
      n_eff = COORD_W'(MAX_N);
    end else begin
      n_eff = grid_size_r;
    end
  end

  // Load position: a load after a full grid starts a new one
  always_comb begin
    restart = grid_loaded_r || (load_row_r > n_eff) || (load_col_r > n_eff) ||
              (load_row_r == '0) || (load_col_r == '0);
    eff_row = restart ? COORD_W'(1) : load_row_r;
    eff_col = restart ? COORD_W'(1) : load_col_r;
    pfx_nxt = ((eff_col == COORD_W'(1)) ? '0 : running_r) +
              PFX_W'(in_element_value[USE_W-1:0]);
    wr_addr = {ROW_W'(eff_row - COORD_W'(1)), ROW_W'(eff_col - COORD_W'(1))};
    grid_loaded_nxt = (eff_col == n_eff) && (eff_row == n_eff);
    if (eff_col == n_eff) begin
      load_col_nxt = COORD_W'(1);
      load_row_nxt = (eff_row == n_eff) ? COORD_W'(1) : eff_row + COORD_W'(1);
    end else begin
      load_col_nxt = eff_col + COORD_W'(1);
      load_row_nxt = eff_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r   <= GRID_SIZE_RST;
      load_row_r    <= COORD_W'(1);
      load_col_r    <= COORD_W'(1);
      running_r     <= '0;
      grid_loaded_r <= 1'b0;
    end else if (cmd.cfg_we) begin
      grid_size_r   <= cfg_grid_size;
      load_row_r    <= COORD_W'(1);
      load_col_r    <= COORD_W'(1);
      running_r     <= '0;
      grid_loaded_r <= 1'b0;
    end else if (cmd.load) begin
      load_row_r    <= load_row_nxt;
      load_col_r    <= load_col_nxt;
      running_r     <= pfx_nxt;
      grid_loaded_r <= grid_loaded_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[wr_addr] <= pfx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_right_r <= mem[{q_row_r, q_rcol_r}];
      rd_left_r  <= mem[{q_row_r, q_lcol_r}];
    end
  end

  // Query check against the grid as it stands now
  assign stat.query_ok = grid_loaded_r &&
                         (in_top_row != '0) && (in_left_col != '0) &&
                         (in_top_row <= in_bottom_row) && (in_left_col <= in_right_col) &&
                         (in_bottom_row <= n_eff) && (in_right_col <= n_eff);
  assign stat.last_row = (q_row_r == q_last_r);
  assign stat.out_busy = out_valid_r && out_stall;

  // Rectangle bounds, zero-based
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_row_r   <= ROW_W'(in_top_row - COORD_W'(1));
      q_last_r  <= ROW_W'(in_bottom_row - COORD_W'(1));
      q_rcol_r  <= ROW_W'(in_right_col - COORD_W'(1));
      q_lcol_r  <= ROW_W'(in_left_col - COORD_W'(2));
      q_lzero_r <= (in_left_col == COORD_W'(1));
    end else if (cmd.issue) begin
      q_row_r <= q_row_r + ROW_W'(1);
    end
  end

  assign diff = rd_right_r - (q_lzero_r ? '0 : rd_left_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r <= '0;
    end else if (rd_vld_r) begin
      acc_r <= acc_r + SUM_W'(diff);
    end
  end

  // Output register: reload on post, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.post_ok || cmd.post_err) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post_ok) begin
      rect_sum_r    <= acc_r;
      query_error_r <= 1'b0;
    end else if (cmd.post_err) begin
      rect_sum_r    <= '0;
      query_error_r <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rect_sum    = rect_sum_r;
  assign out_query_error = query_error_r;

endmodule

>>> rtl/rect_range_sum_query_unit.sv
`timescale 1ns / 1ps

// Rectangle sum unit over a square grid of up to 256 x 256 unsigned 16-bit values.
// Load items carry one element each in row-major order and are taken one per cycle
// while no query or grid_size write is in progress; each is turned into a 24-bit row
// prefix sum and written to a 65536-entry store (one write port, two read ports). A
// query item is checked on arrival: a bad rectangle or an incomplete grid gives a
// registered result of sum 0 with query_error set. A good query reads both prefix
// entries of one row per cycle and holds off the input until its result is posted,
// also waiting for a full output register. Loads continue while a result waits to be
// taken. Writing grid_size restarts loading; the store needs no clearing after reset.
module rect_range_sum_query_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [rrsq_pkg::ELEM_W-1:0]   in_element_value,
  input  logic [rrsq_pkg::COORD_W-1:0]  in_top_row,
  input  logic [rrsq_pkg::COORD_W-1:0]  in_left_col,
  input  logic [rrsq_pkg::COORD_W-1:0]  in_bottom_row,
  input  logic [rrsq_pkg::COORD_W-1:0]  in_right_col,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rrsq_pkg::SUM_W-1:0]    out_rect_sum,
  output logic                          out_query_error,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rrsq_pkg::COORD_W-1:0]  cfg_grid_size
);
  import rrsq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rrsq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  rrsq_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_grid_size    (cfg_grid_size),
    .in_element_value (in_element_value),
    .in_top_row       (in_top_row),
    .in_left_col      (in_left_col),
    .in_bottom_row    (in_bottom_row),
    .in_right_col     (in_right_col),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rect_sum     (out_rect_sum),
    .out_query_error  (out_query_error)
  );

endmodule

>>> rtl/rrsq_chk.sv
`timescale 1ns / 1ps

module rrsq_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        in_req_type,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [rrsq_pkg::SUM_W-1:0]  out_rect_sum,
  input logic                        out_query_error,
  input logic                        cfg_ready
);
  import rrsq_pkg::*;

  // A stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rect_sum) &&
                               $stable(out_query_error))
    else $error("stalled result item changed");

  // Error results carry a zero sum
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_query_error |-> out_rect_sum == '0)
    else $error("error result with nonzero sum");

  // While a query is in progress no item is taken
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_ready |-> in_stall)
    else $error("item taken while a query is in progress");

  // A load never produces a result
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_req_type == REQ_LOAD && !out_valid |=> !out_valid)
    else $error("result appeared after a load item");

endmodule

bind rect_range_sum_query_unit rrsq_chk u_rrsq_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_req_type     (in_req_type),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_rect_sum    (out_rect_sum),
  .out_query_error (out_query_error),
  .cfg_ready       (cfg_ready)
);

>>> tb/rrsq_checker.sv
`timescale 1ns / 1ps

module rrsq_checker
  import rrsq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_req_type,
  input  logic [ELEM_W-1:0]  in_element_value,
  input  logic [COORD_W-1:0] in_top_row,
  input  logic [COORD_W-1:0] in_left_col,
  input  logic [COORD_W-1:0] in_bottom_row,
  input  logic [COORD_W-1:0] in_right_col,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [SUM_W-1:0]   out_rect_sum,
  input  logic               out_query_error,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [COORD_W-1:0] cfg_grid_size,
  output int                 fail_count,
  output int                 results_due
);

  typedef struct packed {
    logic [SUM_W-1:0] rect_sum;
    logic             query_error;
  } rect_result_t;

  logic [PFX_W-1:0] prefix_mem [0:DEPTH-1];
  int unsigned      side_len;
  int unsigned      next_row;
  int unsigned      next_col;
  logic [PFX_W-1:0] row_run;
  logic             grid_full;
  rect_result_t     sums_due[$];
  rect_result_t     oldest;
  int               mismatches = 0;

  function automatic int unsigned active_side();
    if (side_len == 0) return 1;
    if (side_len > MAX_N) return MAX_N;
    return side_len;
  endfunction

  function automatic void restart_fill();
    next_row = 1;
    next_col = 1;
    row_run = '0;
    grid_full = 1'b0;
  endfunction

  function automatic void take_element(logic [ELEM_W-1:0] v);
    int unsigned n;
    n = active_side();
    if (grid_full) restart_fill();
    if (next_row < 1 || next_row > n || next_col < 1 || next_col > n) restart_fill();
    if (next_col == 1) row_run = '0;
    row_run = row_run + PFX_W'(v[USE_W-1:0]);
    prefix_mem[(next_row - 1) * MAX_N + (next_col - 1)] = row_run;
    // advance in row-major order, flag the grid once its last cell lands
    if (next_col == n) begin
      next_col = 1;
      if (next_row == n) begin
        next_row = 1;
        grid_full = 1'b1;
      end else begin
        next_row++;
      end
    end else begin
      next_col++;
    end
  endfunction

  function automatic logic [PFX_W-1:0] prefix_of(int unsigned r, int unsigned c);
    if (c == 0) return '0;
    return prefix_mem[(r - 1) * MAX_N + (c - 1)];
  endfunction

  function automatic rect_result_t rect_total(logic [COORD_W-1:0] t, logic [COORD_W-1:0] l,
                                             logic [COORD_W-1:0] b, logic [COORD_W-1:0] rc);
    rect_result_t      res;
    longint unsigned   acc;
    int unsigned       n;
    int unsigned       row;
    logic              ok;
    n = active_side();
    acc = 0;
    ok = grid_full && t >= 1 && l >= 1 && t <= b && l <= rc && b <= n && rc <= n;
    if (ok) begin
      for (row = t; row <= b; row++) begin
        acc += longint'(prefix_of(row, rc)) - longint'(prefix_of(row, l - 1));
      end
    end
    res.rect_sum = SUM_W'(acc);
    res.query_error = !ok;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      side_len = GRID_SIZE_RST;
      restart_fill();
      sums_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        side_len = cfg_grid_size;
        restart_fill();
      end
      if (out_valid && !out_stall) begin
        if (sums_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result sum %0d err %0b", $realtime, out_rect_sum,
                     out_query_error);
          mismatches++;
        end else begin
          oldest = sums_due.pop_front();
          if (out_rect_sum !== oldest.rect_sum || out_query_error !== oldest.query_error) begin
            if (mismatches < 10)
              $display("%0t: result mismatch: expected sum %0d err %0b, got sum %0d err %0b",
                       $realtime, oldest.rect_sum, oldest.query_error, out_rect_sum,
                       out_query_error);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_req_type == REQ_LOAD)
          take_element(in_element_value);
        else
          sums_due.push_back(rect_total(in_top_row, in_left_col, in_bottom_row, in_right_col));
      end
    end
    fail_count <= mismatches;
    results_due <= sums_due.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rrsq_pkg::*;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int ITEMS_PER_PASS = 260;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_req_type;
  logic [ELEM_W-1:0]  in_element_value;
  logic [COORD_W-1:0] in_top_row;
  logic [COORD_W-1:0] in_left_col;
  logic [COORD_W-1:0] in_bottom_row;
  logic [COORD_W-1:0] in_right_col;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [SUM_W-1:0]   out_rect_sum;
  logic               out_query_error;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [COORD_W-1:0] cfg_grid_size;

  int fail_count;
  int results_due;
  int send_idle_pct;
  int recv_idle_pct;
  int items_sent = 0;
  int cycle_count = 0;
  int goal;

  always #5 clk = ~clk;

  rect_range_sum_query_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_element_value (in_element_value),
    .in_top_row       (in_top_row),
    .in_left_col      (in_left_col),
    .in_bottom_row    (in_bottom_row),
    .in_right_col     (in_right_col),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rect_sum     (out_rect_sum),
    .out_query_error  (out_query_error),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_grid_size    (cfg_grid_size)
  );

  rrsq_checker i_checker (.*);

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_item(input logic kind, input logic [ELEM_W-1:0] value,
                           input logic [COORD_W-1:0] t, input logic [COORD_W-1:0] l,
                           input logic [COORD_W-1:0] b, input logic [COORD_W-1:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= kind;
    // fill the fields the block ignores with noise
    in_element_value <= (kind == REQ_LOAD) ? value : ELEM_W'($urandom);
    in_top_row <= (kind == REQ_QUERY) ? t : COORD_W'($urandom);
    in_left_col <= (kind == REQ_QUERY) ? l : COORD_W'($urandom);
    in_bottom_row <= (kind == REQ_QUERY) ? b : COORD_W'($urandom);
    in_right_col <= (kind == REQ_QUERY) ? r : COORD_W'($urandom);
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic load_cell(input logic [ELEM_W-1:0] value);
    push_item(REQ_LOAD, value, '0, '0, '0, '0);
  endtask

  task automatic ask_rect(input int unsigned t, input int unsigned l, input int unsigned b,
                          input int unsigned r);
    push_item(REQ_QUERY, '0, COORD_W'(t), COORD_W'(l), COORD_W'(b), COORD_W'(r));
  endtask

  task automatic pause_until_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic set_grid_size(input int unsigned size_val);
    pause_until_done();
    // let trailing load writes settle before restarting the grid
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_grid_size <= COORD_W'(size_val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ELEM_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '1;
    if (r < 15) return '0;
    return ELEM_W'($urandom);
  endfunction

  task automatic fill_grid(input int unsigned count);
    repeat (count) load_cell(pick_value());
  endtask

  task automatic ask_good_rect(input int unsigned n);
    int unsigned t, l, b, r;
    if ($urandom_range(9) == 0) begin
      ask_rect(1, 1, n, n);
    end else begin
      t = $urandom_range(1, n);
      b = $urandom_range(t, n);
      l = $urandom_range(1, n);
      r = $urandom_range(l, n);
      ask_rect(t, l, b, r);
    end
  endtask

  task automatic ask_bad_rect(input int unsigned n);
    int unsigned t, l, b, r;
    t = $urandom_range(1, n);
    b = $urandom_range(t, n);
    l = $urandom_range(1, n);
    r = $urandom_range(l, n);
    case ($urandom_range(4))
      0: begin
        t = $urandom_range(511);
        l = $urandom_range(511);
        b = $urandom_range(511);
        r = $urandom_range(511);
      end
      1: begin
        case ($urandom_range(3))
          0: t = 0;
          1: l = 0;
          2: b = 0;
          default: r = 0;
        endcase
      end
      2: begin
        t = $urandom_range(2, n + 1);
        b = $urandom_range(1, t - 1);
      end
      3: begin
        l = $urandom_range(2, n + 1);
        r = $urandom_range(1, l - 1);
      end
      default: begin
        if ($urandom_range(1)) b = $urandom_range(n + 1, 511);
        else r = $urandom_range(n + 1, 511);
      end
    endcase
    ask_rect(t, l, b, r);
  endtask

  task automatic run_epoch();
    int unsigned r, size_val, n, k;
    r = $urandom_range(99);
    if (r < 5) begin
      case ($urandom_range(2))
        0: size_val = 256;
        1: size_val = 300;
        default: size_val = 511;
      endcase
    end else if (r < 9) begin
      size_val = 0;
    end else if (r < 14) begin
      size_val = $urandom_range(9, 16);
    end else begin
      size_val = $urandom_range(1, 6);
    end
    set_grid_size(size_val);
    n = (size_val == 0) ? 1 : (size_val > MAX_N) ? MAX_N : size_val;

    // large grids stay partly loaded, so every query there reports an error
    if (n > 16) begin
      ask_good_rect(n);
      fill_grid($urandom_range(1, 40));
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(1)) ask_good_rect(n);
        else ask_bad_rect(n);
      end
    end else begin
      if ($urandom_range(3) == 0) begin
        k = $urandom_range(0, n * n - 1);
        fill_grid(k);
        ask_good_rect(n);
        fill_grid(n * n - k);
      end else begin
        fill_grid(n * n);
      end
      repeat ($urandom_range(4, 16)) begin
        r = $urandom_range(99);
        if (r < 75) begin
          ask_good_rect(n);
        end else if (r < 92) begin
          ask_bad_rect(n);
        end else begin
          // a stray load drops the finished grid and starts a new one
          load_cell(pick_value());
          ask_good_rect(n);
          if ($urandom_range(1)) fill_grid(n * n - 1);
        end
        if ($urandom_range(99) < 6) pause_until_done();
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_LOAD;
    in_element_value = '0;
    in_top_row = '0;
    in_left_col = '0;
    in_bottom_row = '0;
    in_right_col = '0;
    cfg_valid = 1'b0;
    cfg_grid_size = '0;
    send_idle_pct = 31;
    recv_idle_pct = 87;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // nothing loaded yet at the reset size
    ask_rect(1, 1, 1, 1);
    ask_rect(256, 256, 256, 256);

    set_grid_size(1);
    load_cell(16'hFFFF);
    ask_rect(1, 1, 1, 1);
    ask_rect(0, 1, 1, 1);
    ask_rect(1, 1, 2, 1);
    load_cell(16'h0000);
    ask_rect(1, 1, 1, 1);

    set_grid_size(2);
    load_cell(16'hFFFF);
    load_cell(16'h8000);
    load_cell(16'h0001);
    load_cell(16'h7FFF);
    ask_rect(1, 1, 2, 2);
    ask_rect(2, 2, 2, 2);
    ask_rect(2, 1, 1, 2);
    ask_rect(1, 2, 2, 1);
    ask_rect(511, 511, 511, 511);
    load_cell(16'h5555);
    load_cell(16'hAAAA);
    ask_rect(1, 1, 1, 2);

    // zero acts as one, oversize acts as the maximum
    set_grid_size(0);
    load_cell(16'h1234);
    ask_rect(1, 1, 1, 1);
    set_grid_size(511);
    ask_rect(1, 1, 256, 256);
    ask_rect(1, 1, 257, 1);

    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      goal = items_sent + ITEMS_PER_PASS;
      while (items_sent < goal) run_epoch();
    end

    pause_until_done();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && results_due == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> rect_range_sum_query_unit.f
rtl/rrsq_pkg.sv
rtl/rrsq_ctrl.sv
rtl/rrsq_dp.sv
rtl/rect_range_sum_query_unit.sv
rtl/rrsq_chk.sv
tb/rrsq_checker.sv
tb/tb_top.sv
